FILE: design/scle_pkg.sv
// Package for the scancode line editor: item structs, event and action codes,
// scancode constants and the command/status structs between controller and datapath.
// No dependencies.
package scle_pkg;

  localparam int LINE_CAPACITY_DEF = 64;
  localparam int KEYMAP_ENTRIES    = 128;
  localparam int KMAP_AW           = $clog2(KEYMAP_ENTRIES);
  localparam int POS_W             = 7;

  localparam logic [7:0] REPEAT_DELAY_RST = 8'd12;

  localparam logic [1:0] ACT_POLL      = 2'd0;
  localparam logic [1:0] ACT_MAP_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ      = 2'd2;

  localparam logic [7:0] SC_ESC         = 8'd1;
  localparam logic [7:0] SC_BACK        = 8'd14;
  localparam logic [7:0] SC_ENTER       = 8'd28;
  localparam logic [7:0] SC_LSHIFT      = 8'd42;
  localparam logic [7:0] SC_RSHIFT      = 8'd54;
  localparam logic [7:0] SC_LAST_CHAR   = 8'd57;
  localparam logic [7:0] SC_LEFT        = 8'd75;
  localparam logic [7:0] SC_RIGHT       = 8'd77;
  localparam logic [7:0] SC_DEL         = 8'd83;
  localparam logic [7:0] SC_RESEND      = 8'd224;
  localparam logic [7:0] SC_RELEASE     = 8'd128;
  localparam logic [7:0] SC_LSHIFT_REL  = SC_LSHIFT + SC_RELEASE;
  localparam logic [7:0] SC_RSHIFT_REL  = SC_RSHIFT + SC_RELEASE;
  localparam logic [7:0] HELD_SAT       = 8'd254;
  localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;

  typedef enum logic [3:0] {
    EV_IGNORED     = 4'd0,
    EV_SHIFT       = 4'd1,
    EV_LEFT        = 4'd2,
    EV_RIGHT       = 4'd3,
    EV_BACKSPACE   = 4'd4,
    EV_DELETE      = 4'd5,
    EV_INSERT      = 4'd6,
    EV_ENTER       = 4'd7,
    EV_ESCAPE      = 4'd8,
    EV_MAP_WRITTEN = 4'd9,
    EV_READ        = 4'd10
  } event_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] scancode;
    logic [6:0] map_index;
    logic [7:0] map_char;
    logic [5:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       event_res;
    logic [POS_W-1:0] cursor;
    logic [POS_W-1:0] length;
    logic [7:0]       char_out;
    logic             line_done;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic lookup;
    logic shift_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic go_lookup;
    logic go_shift;
    logic shift_done;
  } dp_status_t;

endpackage

FILE: design/scancode_line_editor_core.sv
// Top level of the scancode line editor: controller and datapath.
// Depends on scle_pkg, scle_ctrl and scle_dpath.
//
// An item is taken when start is high and busy is low; busy then stays high
// until its result is shown. The result appears on out_item with out_valid
// high for exactly one cycle and cannot be held off by the receiver; a new
// item may be started in that same cycle. Polls, keymap writes and line reads
// pass through the evaluate and finish states, and a poll of a character key
// also passes through the keymap lookup state. Backspace, delete and insert
// move the stored characters after the cursor one position per cycle through
// the single read and write port of the line store in the shift state. The
// repeat delay register may be written whenever the block is idle.
module scancode_line_editor_core
  import scle_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  scle_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  scle_dpath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

FILE: design/scle_ctrl.sv
// Controller state machine of the scancode line editor.
// Depends on scle_pkg for the command and status structs.
module scle_ctrl
  import scle_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_LOOKUP,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (status.go_lookup)     state_nxt = S_LOOKUP;
        else if (status.go_shift) state_nxt = S_SHIFT;
        else                      state_nxt = S_FINISH;
      end
      S_LOOKUP: begin
        state_nxt = status.go_shift ? S_SHIFT : S_FINISH;
      end
      S_SHIFT: begin
        if (status.shift_done) state_nxt = S_FINISH;
      end
      S_FINISH: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = (state_r == S_IDLE) && start;
    cmd.eval       = (state_r == S_EVAL);
    cmd.lookup     = (state_r == S_LOOKUP);
    cmd.shift_step = (state_r == S_SHIFT);
    cmd.finish     = (state_r == S_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

FILE: design/scle_dpath.sv
// Datapath of the scancode line editor: editing state, keymap memory with valid
// bits, line store memory with its shift sequencer, and the result register.
// Depends on scle_pkg.
module scle_dpath
  import scle_pkg::*;
#(
  parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)(
  input  logic       clk,
  input  logic       rst_n,
  input  ctrl_cmd_t  cmd,
  output dp_status_t status,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int CW = $clog2(LINE_CAPACITY + 1);
  localparam int AW = $clog2(LINE_CAPACITY);

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_REMOVE,
    FIN_INSERT
  } fin_t;

  logic [7:0] line_mem [LINE_CAPACITY];
  logic [7:0] kmem     [KEYMAP_ENTRIES];

  in_item_t                  item_r, item_nxt;
  logic [CW-1:0]             cur_r, cur_nxt, len_r, len_nxt, cnt_r, cnt_nxt;
  logic [7:0]                prev_r, prev_nxt, last_r, last_nxt, held_r, held_nxt;
  logic                      shift_r, shift_nxt, done_r, done_nxt;
  logic [7:0]                delay_r, delay_nxt;
  event_t                    ev_r, ev_nxt;
  logic [7:0]                char_r, char_nxt;
  fin_t                      fin_r, fin_nxt;
  logic [AW-1:0]             ptr_r, ptr_nxt, wa_r, wa_nxt;
  logic                      dir_r, dir_nxt, pend_r, pend_nxt;
  logic [7:0]                rdata_r, kmd_r;
  logic                      kv_r;
  logic [KEYMAP_ENTRIES-1:0] kval_r;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_item_r, out_item_nxt;

  logic [CW-1:0]     cur0, len0;
  logic [7:0]        prev0, last0, held0, code, held1, kc, rd_char;
  logic              sh0, filtered, full;
  logic [KMAP_AW-1:0] kaddr;
  logic [AW-1:0]     rd_addr, mem_wa;
  logic [7:0]        mem_wd;
  logic              mem_we, km_we;

  always_comb begin
    cur0     = done_r ? '0 : cur_r;
    len0     = done_r ? '0 : len_r;
    prev0    = done_r ? '0 : prev_r;
    last0    = done_r ? '0 : last_r;
    held0    = done_r ? '0 : held_r;
    sh0      = done_r ? 1'b0 : shift_r;
    code     = (item_r.scancode == 8'd0 || item_r.scancode == SC_RESEND) ?
               last0 : item_r.scancode;
    if (code != prev0)        held1 = 8'd0;
    else if (held0 >= HELD_SAT) held1 = held0 ^ 8'd1;
    else                      held1 = held0 + 8'd1;
    filtered = (held1 != 8'd0 && held1 < delay_r) || held1[0];
    kaddr    = {code[KMAP_AW-2:0], sh0};
    kc       = kv_r ? kmd_r : 8'd0;
    full     = ({1'b0, len_r} + {{CW{1'b0}}, 1'b1}) >= (CW+1)'(LINE_CAPACITY);
    rd_char  = (int'(item_r.read_index) < LINE_CAPACITY) ? rdata_r : 8'd0;
    rd_addr  = cmd.shift_step ? ptr_r : AW'(item_r.read_index);
  end

  always_comb begin
    item_nxt      = item_r;
    cur_nxt       = cur_r;
    len_nxt       = len_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    last_nxt      = last_r;
    held_nxt      = held_r;
    shift_nxt     = shift_r;
    done_nxt      = done_r;
    delay_nxt     = cfg_we ? cfg_data : delay_r;
    ev_nxt        = ev_r;
    char_nxt      = char_r;
    fin_nxt       = fin_r;
    ptr_nxt       = ptr_r;
    wa_nxt        = wa_r;
    dir_nxt       = dir_r;
    pend_nxt      = pend_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_wa        = wa_r;
    mem_wd        = rdata_r;
    km_we         = 1'b0;
    status        = '0;

    if (cmd.load) item_nxt = in_item;

    if (cmd.eval) begin
      ev_nxt   = EV_IGNORED;
      char_nxt = 8'd0;
      fin_nxt  = FIN_NONE;
      case (item_r.action)
        ACT_POLL: begin
          cur_nxt   = cur0;
          len_nxt   = len0;
          done_nxt  = 1'b0;
          prev_nxt  = code;
          last_nxt  = code;
          held_nxt  = held1;
          shift_nxt = sh0;
          if (!filtered) begin
            case (code)
              SC_LSHIFT, SC_RSHIFT: begin
                shift_nxt = 1'b1;
                ev_nxt    = EV_SHIFT;
              end
              SC_LSHIFT_REL, SC_RSHIFT_REL: begin
                shift_nxt = 1'b0;
                ev_nxt    = EV_SHIFT;
              end
              SC_LEFT: begin
                if (cur0 != '0) begin
                  cur_nxt = cur0 - 1'b1;
                  ev_nxt  = EV_LEFT;
                end
              end
              SC_RIGHT: begin
                if (cur0 < len0) begin
                  cur_nxt = cur0 + 1'b1;
                  ev_nxt  = EV_RIGHT;
                end
              end
              SC_BACK: begin
                if (cur0 != '0) begin
                  cur_nxt         = cur0 - 1'b1;
                  ptr_nxt         = AW'(cur0);
                  cnt_nxt         = len0 - cur0;
                  dir_nxt         = 1'b0;
                  pend_nxt        = 1'b0;
                  fin_nxt         = FIN_REMOVE;
                  ev_nxt          = EV_BACKSPACE;
                  status.go_shift = 1'b1;
                end
              end
              SC_DEL: begin
                if (cur0 < len0) begin
                  ptr_nxt         = AW'(cur0 + 1'b1);
                  cnt_nxt         = len0 - cur0 - 1'b1;
                  dir_nxt         = 1'b0;
                  pend_nxt        = 1'b0;
                  fin_nxt         = FIN_REMOVE;
                  ev_nxt          = EV_DELETE;
                  status.go_shift = 1'b1;
                end
              end
              SC_ESC: begin
                done_nxt = 1'b1;
                ev_nxt   = EV_ESCAPE;
              end
              SC_ENTER: begin
                if (len0 < CW'(LINE_CAPACITY)) begin
                  mem_we  = 1'b1;
                  mem_wa  = AW'(len0);
                  mem_wd  = CHAR_NEWLINE;
                  len_nxt = len0 + 1'b1;
                end
                done_nxt = 1'b1;
                ev_nxt   = EV_ENTER;
              end
              default: begin
                if (code <= SC_LAST_CHAR) status.go_lookup = 1'b1;
              end
            endcase
          end
        end
        ACT_MAP_WRITE: begin
          km_we  = 1'b1;
          ev_nxt = EV_MAP_WRITTEN;
        end
        ACT_READ: ev_nxt = EV_READ;
        default:  ev_nxt = EV_IGNORED;
      endcase
    end

    if (cmd.lookup) begin
      if (kc != 8'd0 && !full) begin
        ptr_nxt         = AW'(len_r - 1'b1);
        cnt_nxt         = len_r - cur_r;
        dir_nxt         = 1'b1;
        pend_nxt        = 1'b0;
        char_nxt        = kc;
        fin_nxt         = FIN_INSERT;
        ev_nxt          = EV_INSERT;
        status.go_shift = 1'b1;
      end
    end

    if (cmd.shift_step) begin
      if (cnt_r != '0) begin
        ptr_nxt  = dir_r ? ptr_r - 1'b1 : ptr_r + 1'b1;
        wa_nxt   = dir_r ? ptr_r + 1'b1 : ptr_r - 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        pend_nxt = 1'b1;
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r) begin
        mem_we = 1'b1;
        mem_wa = wa_r;
        mem_wd = rdata_r;
      end
    end
    status.shift_done = (cnt_r == '0) && !pend_r;

    if (cmd.finish) begin
      case (fin_r)
        FIN_REMOVE: len_nxt = len_r - 1'b1;
        FIN_INSERT: begin
          mem_we  = 1'b1;
          mem_wa  = AW'(cur_r);
          mem_wd  = char_r;
          cur_nxt = cur_r + 1'b1;
          len_nxt = len_r + 1'b1;
        end
        default: len_nxt = len_r;
      endcase
      out_valid_nxt          = 1'b1;
      out_item_nxt.event_res = ev_r;
      out_item_nxt.cursor    = POS_W'(cur_nxt);
      out_item_nxt.length    = POS_W'(len_nxt);
      out_item_nxt.char_out  = (item_r.action == ACT_READ) ? rd_char : char_r;
      out_item_nxt.line_done = done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_wa] <= mem_wd;
    rdata_r <= line_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (km_we) kmem[item_r.map_index] <= item_r.map_char;
    kmd_r <= kmem[kaddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kval_r <= '0;
      kv_r   <= 1'b0;
    end else begin
      if (km_we) kval_r[item_r.map_index] <= 1'b1;
      kv_r <= kval_r[kaddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      len_r       <= '0;
      cnt_r       <= '0;
      prev_r      <= '0;
      last_r      <= '0;
      held_r      <= '0;
      shift_r     <= 1'b0;
      done_r      <= 1'b0;
      delay_r     <= REPEAT_DELAY_RST;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      len_r       <= len_nxt;
      cnt_r       <= cnt_nxt;
      prev_r      <= prev_nxt;
      last_r      <= last_nxt;
      held_r      <= held_nxt;
      shift_r     <= shift_nxt;
      done_r      <= done_nxt;
      delay_r     <= delay_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    ev_r       <= ev_nxt;
    char_r     <= char_nxt;
    fin_r      <= fin_nxt;
    ptr_r      <= ptr_nxt;
    wa_r       <= wa_nxt;
    dir_r      <= dir_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

FILE: design/scle_checker.sv
// Port-level checks for the scancode line editor, bound to its top level.
// Depends on scancode_line_editor_core.
module scle_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accepted item did not raise busy or produced an early result");

  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("busy dropped without a result");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy && $past(busy))
    else $error("result shown outside the end of an item");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

endmodule

bind scancode_line_editor_core scle_checker u_scle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

FILE: tb/scancode_line_editor_core_tb.sv
// Self-checking testbench for scancode_line_editor_core: keyboard polls, keymap writes and
// line reads are checked against a behavioral line editor held inside this module.
// Depends on scle_pkg and the scancode_line_editor_core RTL.
module scancode_line_editor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scle_pkg::*;

  localparam int LINE_CAP = LINE_CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = LINE_CAP + 16;
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam logic [7:0] SC_REPEAT = 8'd0;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       out_valid;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        items_queued = 0;
  int        err_count = 0;
  int        cycle_count = 0;
  int        gap_pct = 0;
  logic      item_taken = 1'b0;

  logic [7:0] keymap_img [KEYMAP_ENTRIES];
  logic [7:0] line_img [LINE_CAP];
  bit         line_written [LINE_CAP];
  int         cur_pos, line_len;
  logic [7:0] prev_code, last_code, held_count, repeat_delay;
  logic       shift_on, line_ended;

  scancode_line_editor_core #(.LINE_CAPACITY(LINE_CAP)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void remove_char(int pos);
    int i;
    for (i = pos; i + 1 < line_len && i + 1 < LINE_CAP; i++) begin
      line_img[i] = line_img[i + 1];
    end
    line_len--;
  endfunction

  function automatic event_t apply_scancode(input logic [7:0] raw, output logic [7:0] ch);
    logic [7:0] code;
    logic [7:0] c;
    int i;
    ch = '0;
    if (line_ended) begin
      cur_pos = 0;
      line_len = 0;
      line_ended = 1'b0;
      prev_code = '0;
      last_code = '0;
      held_count = '0;
      shift_on = 1'b0;
    end
    if (raw == SC_REPEAT || raw == SC_RESEND) begin
      code = last_code;
    end else begin
      code = raw;
      last_code = raw;
    end
    if (code != prev_code) begin
      held_count = '0;
    end else if (held_count >= HELD_SAT) begin
      held_count = held_count ^ 8'd1;
    end else begin
      held_count = held_count + 8'd1;
    end
    prev_code = code;

    // Typematic filter: first poll, then even counts once the delay is reached.
    if ((held_count != 0 && held_count < repeat_delay) || held_count[0]) return EV_IGNORED;
    if (code == SC_LSHIFT || code == SC_RSHIFT) begin
      shift_on = 1'b1;
      return EV_SHIFT;
    end
    if (code == SC_LSHIFT_REL || code == SC_RSHIFT_REL) begin
      shift_on = 1'b0;
      return EV_SHIFT;
    end
    if (code == SC_LEFT) begin
      if (cur_pos == 0) return EV_IGNORED;
      cur_pos--;
      return EV_LEFT;
    end
    if (code == SC_RIGHT) begin
      if (cur_pos >= line_len) return EV_IGNORED;
      cur_pos++;
      return EV_RIGHT;
    end
    if (code == SC_BACK) begin
      if (cur_pos == 0) return EV_IGNORED;
      cur_pos--;
      remove_char(cur_pos);
      return EV_BACKSPACE;
    end
    if (code == SC_DEL) begin
      if (cur_pos >= line_len) return EV_IGNORED;
      remove_char(cur_pos);
      return EV_DELETE;
    end
    if (code == SC_ESC) begin
      line_ended = 1'b1;
      return EV_ESCAPE;
    end
    if (code == SC_ENTER) begin
      if (line_len < LINE_CAP) begin
        line_img[line_len] = CHAR_NEWLINE;
        line_written[line_len] = 1'b1;
        line_len++;
      end
      line_ended = 1'b1;
      return EV_ENTER;
    end
    if (code <= SC_LAST_CHAR) begin
      c = keymap_img[{code[5:0], shift_on}];
      if (c == 0 || line_len + 1 >= LINE_CAP) return EV_IGNORED;
      for (i = line_len; i > cur_pos; i--) begin
        line_img[i] = line_img[i - 1];
        line_written[i] = 1'b1;
      end
      line_img[cur_pos] = c;
      line_written[cur_pos] = 1'b1;
      cur_pos++;
      line_len++;
      ch = c;
      return EV_INSERT;
    end
    return EV_IGNORED;
  endfunction

  function automatic out_item_t predict_edit(in_item_t it);
    out_item_t r;
    logic [7:0] ch;
    event_t ev;
    ch = '0;
    case (it.action)
      ACT_POLL: ev = apply_scancode(it.scancode, ch);
      ACT_MAP_WRITE: begin
        keymap_img[it.map_index] = it.map_char;
        ev = EV_MAP_WRITTEN;
      end
      ACT_READ: begin
        ch = line_img[it.read_index];
        ev = EV_READ;
      end
      default: ev = EV_IGNORED;
    endcase
    r.event_res = ev;
    r.cursor = 7'(cur_pos);
    r.length = 7'(line_len);
    r.char_out = ch;
    r.line_done = line_ended;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got_v, want_v);
    err_count++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("unexpected result event", got.event_res, -1);
    end else begin
      want = expected_results.pop_front();
      if (got.event_res !== want.event_res)
        report_mismatch("event", got.event_res, want.event_res);
      if (got.cursor !== want.cursor) report_mismatch("cursor", got.cursor, want.cursor);
      if (got.length !== want.length) report_mismatch("length", got.length, want.length);
      if (got.char_out !== want.char_out)
        report_mismatch("char_out", got.char_out, want.char_out);
      if (got.line_done !== want.line_done)
        report_mismatch("line_done", got.line_done, want.line_done);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      if (rst_n && out_valid) check_result(out_item);
      item_taken = rst_n && start && !busy;
      if (item_taken) expected_results.push_back(predict_edit(in_item));
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!start || item_taken)) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= gap_pct) begin
        in_item <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic in_item_t rand_item();
    in_item_t r;
    r.action = 2'($urandom_range(3));
    r.scancode = 8'($urandom_range(255));
    r.map_index = 7'($urandom_range(KEYMAP_ENTRIES - 1));
    r.map_char = 8'($urandom_range(255));
    r.read_index = 6'($urandom_range(LINE_CAP - 1));
    return r;
  endfunction

  function automatic logic [7:0] pick_char_code();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(SC_LAST_CHAR, SC_ESC + 1));
    end while (c == SC_BACK || c == SC_ENTER || c == SC_LSHIFT || c == SC_RSHIFT);
    return c;
  endfunction

  function automatic logic [7:0] pick_edit_code();
    case ($urandom_range(3))
      0: return SC_LEFT;
      1: return SC_RIGHT;
      2: return SC_BACK;
      default: return SC_DEL;
    endcase
  endfunction

  task automatic push_item(input in_item_t r);
    pending_items.push_back(r);
    items_queued++;
  endtask

  task automatic queue_poll(input logic [7:0] code);
    in_item_t r;
    r = rand_item();
    r.action = ACT_POLL;
    r.scancode = code;
    push_item(r);
  endtask

  task automatic queue_map(input logic [6:0] slot, input logic [7:0] ch);
    in_item_t r;
    r = rand_item();
    r.action = ACT_MAP_WRITE;
    r.map_index = slot;
    r.map_char = ch;
    push_item(r);
  endtask

  // Only positions already written are read back; the written set never shrinks.
  task automatic queue_read();
    int slots[$];
    int i;
    in_item_t r;
    for (i = 0; i < LINE_CAP; i++) begin
      if (line_written[i]) slots.push_back(i);
    end
    if (slots.size() == 0) return;
    r = rand_item();
    r.action = ACT_READ;
    r.read_index = 6'(slots[$urandom_range(slots.size() - 1)]);
    push_item(r);
  endtask

  task automatic type_burst(input int n);
    logic [7:0] code;
    repeat (n) begin
      code = pick_char_code();
      queue_poll(code);
      if ($urandom_range(1)) queue_poll(code | SC_RELEASE);
    end
  endtask

  task automatic hold_key(input logic [7:0] code, input int n);
    queue_poll(code);
    repeat (n - 1) begin
      case ($urandom_range(3))
        0: queue_poll(SC_REPEAT);
        1: queue_poll(SC_RESEND);
        default: queue_poll(code);
      endcase
    end
  endtask

  task automatic fill_line();
    logic [7:0] code, prev;
    prev = '0;
    repeat (LINE_CAP + 2) begin
      do code = pick_char_code(); while (code == prev);
      queue_poll(code);
      prev = code;
    end
  endtask

  task automatic random_round();
    in_item_t r;
    logic [7:0] code;
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      type_burst($urandom_range(12, 1));
    end else if (pick < 50) begin
      repeat ($urandom_range(6, 1)) begin
        code = pick_edit_code();
        queue_poll(code);
        if ($urandom_range(1)) queue_poll(code | SC_RELEASE);
      end
    end else if (pick < 58) begin
      queue_poll($urandom_range(3) == 0 ? SC_ESC : SC_ENTER);
      if ($urandom_range(1)) queue_read();
    end else if (pick < 66) begin
      repeat ($urandom_range(3, 1)) begin
        code = pick_char_code();
        queue_map($urandom_range(1) ? {code[5:0], 1'($urandom_range(1))}
                                    : 7'($urandom_range(KEYMAP_ENTRIES - 1)),
                  $urandom_range(5) == 0 ? 8'd0 : 8'($urandom_range(255, 1)));
      end
    end else if (pick < 74) begin
      repeat ($urandom_range(4, 1)) queue_read();
    end else if (pick < 82) begin
      code = $urandom_range(1) ? pick_char_code() : pick_edit_code();
      hold_key(code, $urandom_range(30, 2));
    end else if (pick < 87) begin
      queue_poll($urandom_range(1) ? SC_LSHIFT : SC_RSHIFT);
      type_burst($urandom_range(4, 1));
      queue_poll($urandom_range(1) ? SC_LSHIFT_REL : SC_RSHIFT_REL);
    end else if (pick < 97) begin
      repeat ($urandom_range(3, 1)) begin
        r = rand_item();
        if (r.action == ACT_READ) queue_read();
        else push_item(r);
      end
    end else begin
      fill_line();
    end
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int upto);
    while (items_queued < upto) begin
      while (pending_items.size() >= 4) begin
        @(posedge clk);
        #1;
      end
      random_round();
    end
  endtask

  task automatic write_delay(input logic [7:0] value);
    @(negedge clk);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    repeat_delay = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_items();
    in_item_t r;
    queue_map(7'(KEYMAP_ENTRIES - 1), 8'hFF);
    queue_map('0, 8'h80);
    queue_map(7'(30 * 2), 8'h61);
    queue_map(7'(30 * 2 + 1), 8'h41);
    queue_map(7'(31 * 2 + 1), 8'h42);
    queue_poll(8'd30);
    queue_poll(SC_REPEAT);
    queue_poll(SC_RESEND);
    queue_poll(SC_LSHIFT);
    queue_poll(8'd30);
    queue_poll(SC_LSHIFT_REL);
    queue_poll(SC_RSHIFT);
    queue_poll(SC_RSHIFT_REL);
    queue_poll(8'd31);
    queue_poll(8'd100);
    queue_poll(8'hFF);
    queue_poll(SC_LEFT);
    queue_poll(SC_BACK);
    queue_poll(SC_BACK | SC_RELEASE);
    queue_poll(SC_BACK);
    queue_poll(SC_LEFT);
    queue_poll(SC_DEL);
    queue_poll(SC_DEL | SC_RELEASE);
    queue_poll(SC_DEL);
    queue_poll(SC_RIGHT);
    r = rand_item();
    r.action = ACT_NONE;
    push_item(r);
    queue_poll(SC_ENTER);
    wait_idle();
    queue_read();
    queue_poll(SC_ESC);
  endtask

  initial begin
    int i;
    for (i = 0; i < KEYMAP_ENTRIES; i++) keymap_img[i] = '0;
    for (i = 0; i < LINE_CAP; i++) begin
      line_img[i] = '0;
      line_written[i] = 1'b0;
    end
    cur_pos = 0;
    line_len = 0;
    prev_code = '0;
    last_code = '0;
    held_count = '0;
    repeat_delay = REPEAT_DELAY_RST;
    shift_on = 1'b0;
    line_ended = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    directed_items();
    wait_idle();

    write_delay(8'd1);
    gap_pct = 0;
    for (i = SC_ESC + 1; i <= SC_LAST_CHAR; i++) begin
      if (i != SC_BACK && i != SC_ENTER && i != SC_LSHIFT && i != SC_RSHIFT) begin
        queue_map(7'(i * 2), 8'($urandom_range(126, 33)));
        queue_map(7'(i * 2 + 1), 8'($urandom_range(255, 1)));
      end
    end
    run_random(450);
    wait_idle();

    write_delay(8'd255);
    gap_pct = 70;
    run_random(620);
    wait_idle();
    run_random(800);
    wait_idle();

    write_delay(8'($urandom_range(40, 2)));
    gap_pct = 10;
    run_random(1000);
    wait_idle();

    write_delay(8'd3);
    gap_pct = 0;
    hold_key($urandom_range(1) ? SC_LEFT : SC_LSHIFT, 300);
    run_random(1400);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
